### design/slt_pkg.sv
// Package for the sorted leaf table: command codes, status codes and the
// item types of both channels. No dependencies.
package slt_pkg;

    typedef enum logic [2:0] {
        CMD_INS_EXT  = 3'd0,
        CMD_LOOK_EXT = 3'd1,
        CMD_DEL_EXT  = 3'd2,
        CMD_INS_META = 3'd3,
        CMD_LOOK_META = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] ino;
        logic [63:0] logical_block;
        logic [63:0] value_in;
        logic [31:0] length_in;
        logic [31:0] flags_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value_out;
        logic [31:0] length_out;
        logic [31:0] flags_out;
    } out_item_t;

endpackage

### design/slt_queue.sv
// Two-entry item queue between the front end and the table engine.
// Depends on slt_pkg.
module slt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  slt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output slt_pkg::in_item_t  out_item
);
    import slt_pkg::*;

    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### design/slt_engine.sv
// Table engine: binary search one probe per cycle, then shift/write or read.
// Depends on slt_pkg.
module slt_engine #(
    parameter int TABLE_ORDER = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  slt_pkg::in_item_t  cmd_item,
    output logic               res_valid,
    input  logic               res_ready,
    output slt_pkg::out_item_t res_item
);
    import slt_pkg::*;

    localparam int IW = $clog2(TABLE_ORDER);
    localparam int CW = $clog2(TABLE_ORDER + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ORDER);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EXEC, S_OUT} state_t;

    state_t     state_reg;
    in_item_t   item_reg;
    logic [CW-1:0] count_reg, lo_reg, hi_reg;
    out_item_t  res_reg;

    logic [63:0] ino_reg [TABLE_ORDER];
    logic [63:0] off_reg [TABLE_ORDER];
    logic [63:0] val_reg [TABLE_ORDER];
    logic [31:0] len_reg [TABLE_ORDER];
    logic [31:0] flg_reg [TABLE_ORDER];

    logic          by_off, is_ins, hit, lt;
    logic [CW-1:0] mid;
    logic [IW-1:0] slot;
    logic [63:0]   probe_key, item_key;
    out_item_t     res_next;
    logic [CW-1:0] count_next;

    assign by_off    = (item_reg.command == CMD_INS_EXT) || (item_reg.command == CMD_LOOK_EXT)
                       || (item_reg.command == CMD_DEL_EXT);
    assign is_ins    = (item_reg.command == CMD_INS_EXT) || (item_reg.command == CMD_INS_META);
    assign mid       = CW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign probe_key = by_off ? off_reg[mid[IW-1:0]] : ino_reg[mid[IW-1:0]];
    assign item_key  = by_off ? item_reg.logical_block : item_reg.ino;
    assign lt        = probe_key < item_key;
    assign slot      = lo_reg[IW-1:0];
    assign hit       = (lo_reg < count_reg) && (ino_reg[slot] == item_reg.ino)
                       && (!by_off || off_reg[slot] == item_reg.logical_block);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_item  = res_reg;

    always_comb begin
        res_next        = '0;
        res_next.status = ST_MISS;
        count_next      = count_reg;
        if (is_ins) begin
            if (count_reg == FULL) begin
                res_next.status = ST_FULL;
            end else begin
                res_next.status = ST_OK;
                count_next      = count_reg + CW'(1);
            end
        end else if (item_reg.command == CMD_DEL_EXT) begin
            if (hit) begin
                res_next.status = ST_OK;
                count_next      = count_reg - CW'(1);
            end
        end else if (item_reg.command == CMD_LOOK_EXT
                     || item_reg.command == CMD_LOOK_META) begin
            if (hit) begin
                res_next.status     = ST_OK;
                res_next.value_out  = val_reg[slot];
                res_next.length_out = len_reg[slot];
                res_next.flags_out  = flg_reg[slot];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC) begin
            if (is_ins && count_reg != FULL) begin
                for (int i = 1; i < TABLE_ORDER; i++) begin
                    if (i > int'(lo_reg) && i <= int'(count_reg)) begin
                        ino_reg[i] <= ino_reg[i-1]; off_reg[i] <= off_reg[i-1];
                        val_reg[i] <= val_reg[i-1]; len_reg[i] <= len_reg[i-1];
                        flg_reg[i] <= flg_reg[i-1];
                    end
                end
                ino_reg[slot] <= item_reg.ino;
                off_reg[slot] <= by_off ? item_reg.logical_block : 64'd0;
                val_reg[slot] <= item_reg.value_in;
                len_reg[slot] <= item_reg.length_in;
                flg_reg[slot] <= by_off ? 32'd0 : item_reg.flags_in;
            end else if (item_reg.command == CMD_DEL_EXT && hit) begin
                for (int i = 0; i < TABLE_ORDER - 1; i++) begin
                    if (i >= int'(lo_reg)) begin
                        ino_reg[i] <= ino_reg[i+1]; off_reg[i] <= off_reg[i+1];
                        val_reg[i] <= val_reg[i+1]; len_reg[i] <= len_reg[i+1];
                        flg_reg[i] <= flg_reg[i+1];
                    end
                end
            end
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        item_reg  <= cmd_item;
                        lo_reg    <= '0;
                        hi_reg    <= count_reg;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (lo_reg >= hi_reg) begin
                        state_reg <= S_EXEC;
                    end else if (lt) begin
                        lo_reg <= mid + CW'(1);
                    end else begin
                        hi_reg <= mid;
                    end
                end
                S_EXEC: begin
                    res_reg   <= res_next;
                    count_reg <= count_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### design/sorted_leaf_table.sv
// Top level of the sorted leaf table: command queue and table engine.
// Depends on slt_pkg, slt_queue and slt_engine.
//
// The s_ channel takes one command item per handshake; the m_ channel returns
// exactly one result item per command, in order. Commands are inserts,
// lookups and deletes keyed on offset (extent) or ino (metadata).
// A two-item queue decouples the input from the engine, so items are taken
// while the engine works or while a result waits for the receiver.
// The engine runs a lower-bound binary search with one probe per cycle,
// then shifts and writes or reads the found slot, then holds the result
// until taken. Each item passes the engine states in order: accept
// (S_IDLE), search with its end check (S_SEARCH), execute (S_EXEC) and
// result (S_OUT). The search needs no probe on an empty table and up to
// six probes with a full 32-entry table. Between s_ and the engine each
// item is first registered in the queue.
// When the receiver stalls the engine holds its result and the queue fills;
// s_ready falls once two items wait. Reset empties the queue and the table
// (count zero); entry storage itself is not cleared. An insert into a full
// table changes nothing and reports the full status.
module sorted_leaf_table #(
    parameter int TABLE_ORDER = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  slt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output slt_pkg::out_item_t m_item
);
    import slt_pkg::*;

    logic     q_valid, q_ready;
    in_item_t q_item;

    slt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    slt_engine #(.TABLE_ORDER(TABLE_ORDER)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_item(q_item),
        .res_valid(m_valid), .res_ready(m_ready), .res_item(m_item)
    );
endmodule
